// ===== hw/rtl/p2rf_pkg.sv =====
package p2rf_pkg;

   // item kinds carried in req_op
   localparam logic OP_FILL = 1'b0;
   localparam logic OP_READ = 1'b1;

   // one 2-bit pixel field
   localparam logic [1:0] PIXEL_MASK = 2'h3;
   localparam int PIXELS_PER_BYTE = 4;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch the incoming item
      logic setup;       // clip the rectangle, seed counters, or fetch a read byte
      logic clr_wr;      // clearing pass: zero one byte
      logic rmw_rd;      // fetch the current byte of the rectangle
      logic rmw_wr;      // write back the merged byte
      logic next_byte;   // step one byte right
      logic next_row;    // step one row down
      logic rsp_load;    // load the result register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;    // clearing pass is on its last byte
      logic is_read;     // captured item is a read
      logic empty;       // clipped rectangle holds no pixel
      logic last_byte;   // current byte is the last one in the row
      logic last_row;    // current row is the last one
   } dp_sts_type;

endpackage

// ===== hw/rtl/packed_2bpp_rect_fill_top.sv =====
// packed 2-bit-per-pixel framebuffer with rectangle fill and byte read-back.
// the store holds SCREEN_W x SCREEN_H pixels, four per byte, (SCREEN_W+3)/4
// bytes per row; pixel x sits at bits 2*(x mod 4). a fill item (req_op = 0)
// paints the rectangle left..left+span_w-1 by top..top+span_h-1 with
// req_colour, ends wrapping at 16 bits and off-screen pixels skipped; it
// answers with a zero byte. a read item (req_op = 1) returns the byte at
// req_byte_addr, or zero when the address lies past the store. every item
// gives exactly one result. after reset a clearing pass zeroes the store one
// byte per cycle, all (SCREEN_W+3)/4*SCREEN_H bytes (19200 by default), with
// req_stall held high. a read goes from setup straight to finish; a fill is
// clipped in setup, skips to finish when empty, else reads and then writes
// back each touched byte in turn. one item is in work at a time; a finished
// result waits in the output register while the next item is taken.
module packed_2bpp_rect_fill_top #(
   parameter int SCREEN_W = 320,
   parameter int SCREEN_H = 240
) (
   input  logic        clock,
   input  logic        reset,
   // item channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_left,
   input  logic [15:0] req_top,
   input  logic [15:0] req_span_w,
   input  logic [15:0] req_span_h,
   input  logic [1:0]  req_colour,
   input  logic [14:0] req_byte_addr,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_byte
);
   import p2rf_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: clearing pass, item decode, byte walk, result hand-off
   p2rf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // clipping, address walk, masked merge and the frame store itself
   p2rf_datapath #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_op        (req_op),
      .req_left      (req_left),
      .req_top       (req_top),
      .req_span_w    (req_span_w),
      .req_span_h    (req_span_h),
      .req_colour    (req_colour),
      .req_byte_addr (req_byte_addr),
      .rsp_read_byte (rsp_read_byte)
   );

endmodule

// ===== hw/rtl/p2rf_datapath.sv =====
module p2rf_datapath #(
   parameter int SCREEN_W = 320,
   parameter int SCREEN_H = 240
) (
   input  logic                clock,
   input  logic                reset,
   input  p2rf_pkg::dp_cmd_type cmd,
   output p2rf_pkg::dp_sts_type sts,
   input  logic                req_op,
   input  logic [15:0]         req_left,
   input  logic [15:0]         req_top,
   input  logic [15:0]         req_span_w,
   input  logic [15:0]         req_span_h,
   input  logic [1:0]          req_colour,
   input  logic [14:0]         req_byte_addr,
   output logic [7:0]          rsp_read_byte
);
   import p2rf_pkg::*;

   localparam int ROW_BYTES   = (SCREEN_W + 3) / 4;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_H;
   localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int BXW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int XW  = $clog2(SCREEN_W + 1);
   localparam int YW  = $clog2(SCREEN_H + 1);

   // captured item
   logic          op_ff;
   logic [15:0]   left_ff, top_ff, span_w_ff, span_h_ff;
   logic [1:0]    colour_ff;
   logic [AW-1:0] raddr_ff;
   logic          read_ok_ff;

   // walk state
   logic [XW-1:0]  x_end_ff, x_end_in;
   logic [YW-1:0]  y_end_ff, y_end_in;
   logic [YW-1:0]  cur_y_ff, cur_y_in;
   logic [BXW-1:0] cur_bx_ff, cur_bx_in;
   logic [AW-1:0]  row_base_ff, row_base_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;

   logic [15:0]    x_sum, y_sum;
   logic [BXW-1:0] first_bx, last_bx;
   logic [XW-1:0]  x_last;
   logic [AW-1:0]  rmw_addr, mem_raddr, mem_waddr;
   logic [7:0]     pix_mask, merged, mem_wdata;
   logic           mem_we, mem_re;
   logic [7:0]     rdata_ff;
   logic [7:0]     rsp_ff, rsp_in;

   logic [7:0]     mem [STORE_BYTES];

   // clip: end wraps at 16 bits, then limited to the screen
   assign x_sum    = left_ff + span_w_ff;
   assign y_sum    = top_ff + span_h_ff;
   assign x_end_in = (x_sum < 16'(SCREEN_W)) ? XW'(x_sum) : XW'(SCREEN_W);
   assign y_end_in = (y_sum < 16'(SCREEN_H)) ? YW'(y_sum) : YW'(SCREEN_H);

   assign first_bx = BXW'(left_ff >> 2);
   assign x_last   = x_end_ff - 1'b1;
   assign last_bx  = BXW'(x_last >> 2);
   assign rmw_addr = row_base_ff + AW'(cur_bx_ff);

   // pixels of the current byte that fall inside the clipped span
   always_comb begin
      logic [15:0] px;
      pix_mask = '0;
      for (int p = 0; p < PIXELS_PER_BYTE; p++) begin
         px = (16'(cur_bx_ff) << 2) | 16'(p);
         if ((px >= left_ff) && (px < 16'(x_end_ff))) begin
            pix_mask[2*p +: 2] = PIXEL_MASK;
         end
      end
   end

   assign merged = (rdata_ff & ~pix_mask) | ({PIXELS_PER_BYTE{colour_ff}} & pix_mask);

   assign mem_we    = cmd.clr_wr | cmd.rmw_wr;
   assign mem_waddr = cmd.clr_wr ? clr_addr_ff : rmw_addr;
   assign mem_wdata = cmd.clr_wr ? 8'h00 : merged;
   assign mem_re    = cmd.rmw_rd | (cmd.setup & op_ff & read_ok_ff);
   assign mem_raddr = cmd.rmw_rd ? rmw_addr : raddr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         left_ff    <= req_left;
         top_ff     <= req_top;
         span_w_ff  <= req_span_w;
         span_h_ff  <= req_span_h;
         colour_ff  <= req_colour;
         raddr_ff   <= AW'(req_byte_addr);
         read_ok_ff <= (32'(req_byte_addr) < 32'(STORE_BYTES));
      end
   end

   always_comb begin
      cur_y_in    = cur_y_ff;
      cur_bx_in   = cur_bx_ff;
      row_base_in = row_base_ff;
      if (cmd.setup) begin
         cur_y_in    = YW'(top_ff);
         cur_bx_in   = first_bx;
         row_base_in = AW'(top_ff[YW-1:0] * ROW_BYTES);
      end else if (cmd.next_row) begin
         cur_y_in    = cur_y_ff + 1'b1;
         cur_bx_in   = first_bx;
         row_base_in = row_base_ff + AW'(ROW_BYTES);
      end else if (cmd.next_byte) begin
         cur_bx_in   = cur_bx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_y_ff    <= cur_y_in;
      cur_bx_ff   <= cur_bx_in;
      row_base_ff <= row_base_in;
      if (cmd.setup) begin
         x_end_ff <= x_end_in;
         y_end_ff <= y_end_in;
      end
   end

   assign clr_addr_in = cmd.clr_wr ? (clr_addr_ff + 1'b1) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign rsp_in = (op_ff == OP_READ && read_ok_ff) ? rdata_ff : 8'h00;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_read_byte = rsp_ff;

   assign sts.clr_last  = (clr_addr_ff == AW'(STORE_BYTES - 1));
   assign sts.is_read   = (op_ff == OP_READ);
   assign sts.empty     = (left_ff >= 16'(x_end_ff)) || (top_ff >= 16'(y_end_ff));
   assign sts.last_byte = (cur_bx_ff == last_bx);
   assign sts.last_row  = (YW'(cur_y_ff + 1'b1) == y_end_ff);

endmodule

// ===== hw/rtl/p2rf_ctrl.sv =====
module p2rf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output p2rf_pkg::dp_cmd_type cmd,
   input  p2rf_pkg::dp_sts_type sts
);
   import p2rf_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SETUP  = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_RMW_RD = 3'd4;
   localparam logic [2:0] ST_RMW_WR = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.is_read ? ST_FINISH : ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.empty ? ST_FINISH : ST_RMW_RD;
         end
         ST_RMW_RD: begin
            cmd.rmw_rd = 1'b1;
            state_in   = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            cmd.rmw_wr = 1'b1;
            state_in   = ST_RMW_RD;
            if (!sts.last_byte) begin
               cmd.next_byte = 1'b1;
            end else if (!sts.last_row) begin
               cmd.next_row = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/p2rf_checker.sv =====
module p2rf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_read_byte
);

   // clearing pass holds off items right after reset
   a_stall_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> req_stall)
      else $error("item port open right after reset");

   // one item at a time: an accepted item closes the port
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is in work");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_read_byte))
      else $error("stalled result changed");

endmodule

bind packed_2bpp_rect_fill_top p2rf_checker u_p2rf_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import p2rf_pkg::*;

   // screen geometry, matching the instance below
   localparam int SCREEN_W    = 320;
   localparam int SCREEN_H    = 240;
   localparam int ROW_BYTES   = (SCREEN_W + 3) / 4;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_H;

   // clearing pass plus a handful of full-screen fills, taken several times over
   localparam int CYCLE_LIMIT  = 2000000;
   // extra wait at the end so that a stray result still shows
   localparam int DRAIN_CYCLES = 40;

   // one request item as driven onto the req_ ports
   typedef struct {
      logic        op;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] span_w;
      logic [15:0] span_h;
      logic [1:0]  colour;
      logic [14:0] byte_addr;
   } fb_item_type;

   // one awaited result, with enough context to report a mismatch
   typedef struct {
      logic        op;
      logic [14:0] addr;
      logic [7:0]  value;
   } fb_expect_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic        req_op        = OP_FILL;
   logic [15:0] req_left      = '0;
   logic [15:0] req_top       = '0;
   logic [15:0] req_span_w    = '0;
   logic [15:0] req_span_h    = '0;
   logic [1:0]  req_colour    = '0;
   logic [14:0] req_byte_addr = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [7:0]  rsp_read_byte;

   // shadow copy of the framebuffer, updated as items are accepted
   logic [7:0] frame_model [STORE_BYTES];
   // results still owed by the block, oldest first
   fb_expect_type pending_bytes [$];

   // idle and stall rates in percent, changed per phase
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   int error_count   = 0;
   int checked_count = 0;
   int fill_count    = 0;
   int read_count    = 0;
   int oob_reads     = 0;
   int cycle_count   = 0;

   // byte near the last on-screen fill, so reads land on painted pixels
   int near_base       = 0;
   // full-size fills are slow, so only a few are allowed in random traffic
   int big_fill_budget = 4;

   packed_2bpp_rect_fill_top #(
      .SCREEN_W(SCREEN_W),
      .SCREEN_H(SCREEN_H)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_left     (req_left),
      .req_top      (req_top),
      .req_span_w   (req_span_w),
      .req_span_h   (req_span_h),
      .req_colour   (req_colour),
      .req_byte_addr(req_byte_addr),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_read_byte(rsp_read_byte)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("packed_2bpp_rect_fill_top verification failed");
      $finish;
   end

   // random result back-pressure at the current phase rate
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // apply one accepted item to the shadow framebuffer and return its result byte
   function automatic logic [7:0] apply_to_model(input fb_item_type it);
      logic [15:0] x_stop;
      logic [15:0] y_stop;
      int          x_end;
      int          y_end;
      int          x;
      int          y;
      int          idx;
      if (it.op == OP_READ) begin
         return (it.byte_addr < STORE_BYTES) ? frame_model[it.byte_addr] : 8'h00;
      end
      // 16-bit sums: a wrapped end falls below the start and paints nothing
      x_stop = it.left + it.span_w;
      y_stop = it.top + it.span_h;
      x_end  = (x_stop < SCREEN_W) ? x_stop : SCREEN_W;
      y_end  = (y_stop < SCREEN_H) ? y_stop : SCREEN_H;
      for (y = it.top; y < y_end; y++) begin
         for (x = it.left; x < x_end; x++) begin
            idx = y * ROW_BYTES + x / 4;
            frame_model[idx][(x % 4) * 2 +: 2] = it.colour & PIXEL_MASK;
         end
      end
      return 8'h00;
   endfunction

   // fill item; byte_addr is ignored by the block, so it carries noise
   function automatic fb_item_type fill_item(input int left, input int top, input int span_w,
                                             input int span_h, input int colour);
      fb_item_type it;
      it.op        = OP_FILL;
      it.left      = 16'(left);
      it.top       = 16'(top);
      it.span_w    = 16'(span_w);
      it.span_h    = 16'(span_h);
      it.colour    = 2'(colour);
      it.byte_addr = 15'($urandom_range(0, 32767));
      return it;
   endfunction

   // read item; the rectangle fields are ignored, so they carry noise
   function automatic fb_item_type read_item(input int addr);
      fb_item_type it;
      it.op        = OP_READ;
      it.left      = 16'($urandom_range(0, 65535));
      it.top       = 16'($urandom_range(0, 65535));
      it.span_w    = 16'($urandom_range(0, 65535));
      it.span_h    = 16'($urandom_range(0, 65535));
      it.colour    = 2'($urandom_range(0, 3));
      it.byte_addr = 15'(addr);
      return it;
   endfunction

   // offer one item, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_item(input fb_item_type it);
      fb_expect_type ex;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= it.op;
      req_left      <= it.left;
      req_top       <= it.top;
      req_span_w    <= it.span_w;
      req_span_h    <= it.span_h;
      req_colour    <= it.colour;
      req_byte_addr <= it.byte_addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: predict in acceptance order
      ex.op    = it.op;
      ex.addr  = it.byte_addr;
      ex.value = apply_to_model(it);
      pending_bytes.push_back(ex);
      if (it.op == OP_READ) begin
         read_count++;
         if (it.byte_addr >= STORE_BYTES) oob_reads++;
      end else begin
         fill_count++;
      end
   endtask

   // take valid down and wait until every owed result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // result checker: every accepted result against the oldest expectation
   always @(posedge clock) begin
      fb_expect_type ex;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %02h",
                     $realtime, rsp_read_byte);
            error_count++;
         end else begin
            ex = pending_bytes.pop_front();
            checked_count++;
            if (rsp_read_byte !== ex.value) begin
               $display("%0t: %s result mismatch (byte_addr %0d), expected %02h, actual %02h",
                        $realtime, (ex.op == OP_READ) ? "read" : "fill", ex.addr,
                        ex.value, rsp_read_byte);
               error_count++;
            end
         end
      end
   end

   // single pixels at both corners and one-pixel-wide lines
   task automatic test_pixel_and_line_fills();
      send_item(read_item(0));
      send_item(fill_item(0, 0, 1, 1, 3));
      send_item(read_item(0));
      send_item(fill_item(SCREEN_W - 1, SCREEN_H - 1, 1, 1, 2));
      send_item(read_item(STORE_BYTES - 1));
      // horizontal line in row 5, vertical line at column 6
      send_item(fill_item(1, 5, 10, 1, 1));
      send_item(read_item(5 * ROW_BYTES + 2));
      send_item(fill_item(6, 0, 1, SCREEN_H, 2));
      send_item(read_item((SCREEN_H - 1) * ROW_BYTES + 1));
   endtask

   // zero spans, wrapped ends and off-screen parts
   task automatic test_clipping_and_wrap();
      send_item(fill_item(10, 10, 0, 5, 3));
      send_item(fill_item(10, 10, 5, 0, 3));
      // end wraps past 65535 back below the start
      send_item(fill_item(65530, 20, 10, 4, 3));
      send_item(fill_item(20, 65533, 4, 8, 1));
      send_item(fill_item(2, 30, 65535, 3, 1));
      // partly beyond the right and bottom edges
      send_item(fill_item(SCREEN_W - 4, SCREEN_H - 2, 20, 5, 3));
      send_item(read_item(STORE_BYTES - 1));
      // wholly off screen
      send_item(fill_item(400, 10, 8, 8, 3));
      send_item(fill_item(10, 300, 8, 8, 3));
      // huge spans that clip to the screen edge without wrapping
      send_item(fill_item(0, 200, 65535, 60000, 2));
      send_item(read_item(200 * ROW_BYTES));
   endtask

   // reads past the end of the store
   task automatic test_out_of_range_reads();
      send_item(read_item(STORE_BYTES));
      send_item(read_item(32767));
   endtask

   // every pixel painted in one item
   task automatic test_whole_screen();
      send_item(fill_item(0, 0, SCREEN_W, SCREEN_H, 1));
      send_item(read_item(STORE_BYTES / 2));
      send_item(read_item(STORE_BYTES - 1));
   endtask

   // fill, let the block run dry, then read the painted bytes
   task automatic test_pause_until_drained();
      int l;
      int t;
      int round;
      for (round = 0; round < 4; round++) begin
         l = $urandom_range(0, SCREEN_W - 1);
         t = $urandom_range(0, SCREEN_H - 1);
         send_item(fill_item(l, t, $urandom_range(1, 24), $urandom_range(1, 8),
                             $urandom_range(0, 3)));
         wait_drained();
         send_item(read_item(t * ROW_BYTES + l / 4));
      end
   endtask

   // mixed random traffic under one idle/stall setting
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_items);
      int i;
      int pick;
      int l;
      int t;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            // reads mostly around the last painted rectangle
            if ($urandom_range(9) < 7)
               send_item(read_item(near_base + $urandom_range(0, 12) +
                                   ROW_BYTES * $urandom_range(0, 15)));
            else
               send_item(read_item($urandom_range(0, 32767)));
         end else if (pick < 85 || (pick >= 95 && big_fill_budget == 0)) begin
            // small rectangles, some hanging off the screen edge
            l = $urandom_range(0, SCREEN_W + 10);
            t = $urandom_range(0, SCREEN_H + 5);
            if (l < SCREEN_W && t < SCREEN_H) near_base = t * ROW_BYTES + l / 4;
            send_item(fill_item(l, t, $urandom_range(0, 48), $urandom_range(0, 16),
                                $urandom_range(0, 3)));
         end else if (pick < 95) begin
            // full-range noise, mostly off screen or wrapped
            send_item(fill_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 3)));
         end else begin
            // occasional large rectangle
            big_fill_budget--;
            l = $urandom_range(0, SCREEN_W - 1);
            t = $urandom_range(0, SCREEN_H - 1);
            near_base = t * ROW_BYTES + l / 4;
            send_item(fill_item(l, t, $urandom_range(0, SCREEN_W + 80),
                                $urandom_range(0, SCREEN_H + 20), $urandom_range(0, 3)));
         end
      end
   endtask

   // test sequence
   initial begin
      foreach (frame_model[i]) frame_model[i] = 8'h00;

      // release reset; the clearing pass then holds req_stall high
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_pixel_and_line_fills();
      test_clipping_and_wrap();
      test_out_of_range_reads();
      test_whole_screen();

      // no idling, sender idle, receiver stalling, both
      test_random_traffic(0, 0, 18);
      test_random_traffic(60, 0, 18);
      test_random_traffic(0, 60, 18);
      test_random_traffic(26, 26, 18);
      test_pause_until_drained();

      // all items in: let the last results come out, then look for strays
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d fills and %0d reads (%0d past the store end)",
               fill_count, read_count, oob_reads);
      $display("%0d results compared under four idle/stall mixes, %0d mismatches",
               checked_count, error_count);
      if (error_count == 0)
         $display("packed_2bpp_rect_fill_top verification clean");
      else
         $display("packed_2bpp_rect_fill_top verification failed");
      $finish;
   end

endmodule
